@@ rtl/core/trs_pkg.sv @@
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types, constants and helpers for the threshold run segmenter.
// ----------------------------------------------------------------------------
package trs_pkg;

  // Sample index width; the counter wraps at MaxSamples
  localparam int unsigned IdxW       = 20;
  localparam int unsigned MaxSamples = 1 << IdxW;

  localparam int unsigned GainW  = 15;
  localparam int unsigned LossW  = 16;
  localparam int unsigned SampW  = 16;
  localparam int unsigned MagW   = SampW + 1;
  localparam int unsigned ClassW = 4;
  localparam int unsigned LevelW = 3;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned NumBounds = 4;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegGain0 = 4'd0;
  localparam logic [CfgIdxW-1:0] RegGain1 = 4'd1;
  localparam logic [CfgIdxW-1:0] RegGain2 = 4'd2;
  localparam logic [CfgIdxW-1:0] RegGain3 = 4'd3;
  localparam logic [CfgIdxW-1:0] RegLoss0 = 4'd4;
  localparam logic [CfgIdxW-1:0] RegLoss1 = 4'd5;
  localparam logic [CfgIdxW-1:0] RegLoss2 = 4'd6;
  localparam logic [CfgIdxW-1:0] RegLoss3 = 4'd7;

  // Reset values, Q3.12
  localparam logic [GainW-1:0] GainRst0 = 15'd359;
  localparam logic [GainW-1:0] GainRst1 = 15'd630;
  localparam logic [GainW-1:0] GainRst2 = 15'd879;
  localparam logic [GainW-1:0] GainRst3 = 15'd1110;
  localparam logic signed [LossW-1:0] LossRst0 = -16'sd340;
  localparam logic signed [LossW-1:0] LossRst1 = -16'sd719;
  localparam logic signed [LossW-1:0] LossRst2 = -16'sd1149;
  localparam logic signed [LossW-1:0] LossRst3 = -16'sd1646;

  // Mixture class codes
  localparam logic [ClassW-1:0] ClassLossFull = 4'd0;
  localparam logic [ClassW-1:0] ClassNone     = 4'd4;
  localparam logic [ClassW-1:0] ClassGainFull = 4'd8;
  localparam logic [LevelW-1:0] LevelNone = 3'd0;
  localparam logic [LevelW-1:0] LevelFull = 3'd4;

  typedef enum logic [1:0] {
    KindNeutral = 2'd0,
    KindLoss    = 2'd1,
    KindGain    = 2'd2
  } run_kind_e;

  typedef struct packed {
    logic [NumBounds-1:0][GainW-1:0] gain;
    logic [NumBounds-1:0][LossW-1:0] loss;
  } bounds_t;

  // Segment closed by the run tracker
  typedef struct packed {
    logic                    valid;
    logic [IdxW-1:0]         seg_start;
    logic [IdxW-1:0]         seg_end;
    run_kind_e               kind;
    logic signed [SampW-1:0] extreme;
    logic                    is_final;
  } seg_t;

  function automatic logic [MagW-1:0] mag_of(input logic signed [SampW-1:0] x);
    logic signed [MagW-1:0] e;
    e = MagW'(x);
    return e[MagW-1] ? MagW'(-e) : MagW'(e);
  endfunction

endpackage

@@ rtl/core/trs_classify.sv @@
// ----------------------------------------------------------------------------
// trs_classify
// Sorts one sample into neutral, loss or gain against the level-0 bounds.
// ----------------------------------------------------------------------------
module trs_classify (
  input  logic signed [trs_pkg::SampW-1:0] sample_i,
  input  logic                             is_nan_i,
  input  logic [trs_pkg::GainW-1:0]        gain0_i,
  input  logic signed [trs_pkg::LossW-1:0] loss0_i,
  output trs_pkg::run_kind_e               kind_o
);
  import trs_pkg::*;

  logic signed [MagW-1:0] samp_ext;
  logic signed [MagW-1:0] gain_ext;
  logic at_or_below_loss;
  logic at_or_below_gain;

  assign samp_ext         = MagW'(sample_i);
  assign gain_ext         = $signed({2'b00, gain0_i});
  assign at_or_below_loss = (sample_i <= loss0_i);
  assign at_or_below_gain = (samp_ext <= gain_ext);

  // neutral first, then loss, then gain (holds for inverted bounds too)
  always_comb begin
    priority if (is_nan_i || (!at_or_below_loss && at_or_below_gain)) begin
      kind_o = KindNeutral;
    end else if (at_or_below_loss) begin
      kind_o = KindLoss;
    end else begin
      kind_o = KindGain;
    end
  end

endmodule

@@ rtl/core/trs_run_tracker.sv @@
// ----------------------------------------------------------------------------
// trs_run_tracker
// Run state: open flag, kind, start index, extreme and sample counter.
// Closes a segment on a class change or on the last sample.
// ----------------------------------------------------------------------------
module trs_run_tracker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic signed [trs_pkg::SampW-1:0] sample_i,
  input  logic                             is_nan_i,
  input  logic                             last_i,
  input  trs_pkg::run_kind_e               kind_i,
  output trs_pkg::seg_t                    seg_o
);
  import trs_pkg::*;

  logic                    open_q, open_d;
  run_kind_e               kind_q, kind_d;
  logic [IdxW-1:0]         start_q, start_d;
  logic signed [SampW-1:0] ext_q, ext_d;
  logic [IdxW-1:0]         cnt_q, cnt_d;

  logic                    more_extreme;
  logic signed [SampW-1:0] ext_upd;

  // lower for a loss run, higher for a gain run; NaN never updates
  always_comb begin
    unique case (kind_q)
      KindLoss: more_extreme = !is_nan_i && (sample_i < ext_q);
      KindGain: more_extreme = !is_nan_i && (sample_i > ext_q);
      default:  more_extreme = 1'b0;
    endcase
    ext_upd = more_extreme ? sample_i : ext_q;
  end

  always_comb begin
    open_d  = open_q;
    kind_d  = kind_q;
    start_d = start_q;
    ext_d   = ext_q;
    cnt_d   = cnt_q;

    seg_o.valid     = 1'b0;
    seg_o.seg_start = start_q;
    seg_o.seg_end   = cnt_q;
    seg_o.kind      = kind_q;
    seg_o.extreme   = ext_q;
    seg_o.is_final  = last_i;

    if (last_i) begin
      // last sample joins the open run and closes it
      seg_o.valid   = open_q;
      seg_o.extreme = ext_upd;
      open_d = 1'b0;
      kind_d = KindNeutral;
      ext_d  = '0;
      cnt_d  = '0;
    end else begin
      if (open_q && (kind_i == kind_q)) begin
        ext_d = ext_upd;
      end else begin
        seg_o.valid   = open_q;
        seg_o.seg_end = cnt_q - {{(IdxW-1){1'b0}}, 1'b1};
        open_d  = 1'b1;
        kind_d  = kind_i;
        start_d = cnt_q;
        ext_d   = (kind_i == KindNeutral) ? '0 : sample_i;
      end
      cnt_d = cnt_q + {{(IdxW-1){1'b0}}, 1'b1};
    end

    if (!step_i) begin
      seg_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      kind_q  <= KindNeutral;
      start_q <= '0;
      ext_q   <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      open_q  <= open_d;
      kind_q  <= kind_d;
      start_q <= start_d;
      ext_q   <= ext_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ rtl/core/trs_mixture.sv @@
// ----------------------------------------------------------------------------
// trs_mixture
// Grades a closed run's extreme against four magnitudes into a mixture
// class and a fractional call flag.
// ----------------------------------------------------------------------------
module trs_mixture (
  input  trs_pkg::run_kind_e                kind_i,
  input  logic signed [trs_pkg::SampW-1:0]  extreme_i,
  input  trs_pkg::bounds_t                  bounds_i,
  output logic [trs_pkg::ClassW-1:0]        class_o,
  output logic                              call_o,
  output logic signed [trs_pkg::SampW-1:0]  extreme_o
);
  import trs_pkg::*;

  logic [MagW-1:0]             ext_mag;
  logic [NumBounds-1:0][MagW-1:0] bnd_mag;
  logic [LevelW-1:0]           level;

  assign ext_mag = mag_of(extreme_i);

  always_comb begin
    for (int i = 0; i < NumBounds; i++) begin
      if (kind_i == KindLoss) begin
        bnd_mag[i] = mag_of($signed(bounds_i.loss[i]));
      end else begin
        bnd_mag[i] = MagW'(bounds_i.gain[i]);
      end
    end
  end

  always_comb begin
    priority if (ext_mag >= bnd_mag[3]) begin
      level = LevelFull;
    end else if (ext_mag >= bnd_mag[2]) begin
      level = 3'd3;
    end else if (ext_mag >= bnd_mag[1]) begin
      level = 3'd2;
    end else if (ext_mag >= bnd_mag[0]) begin
      level = 3'd1;
    end else begin
      level = LevelNone;
    end
  end

  always_comb begin
    unique case (kind_i)
      KindLoss: begin
        class_o   = ClassNone - ClassW'(level);
        call_o    = (level != LevelNone) && (level != LevelFull);
        extreme_o = extreme_i;
      end
      KindGain: begin
        class_o   = ClassNone + ClassW'(level);
        call_o    = (level != LevelNone) && (level != LevelFull);
        extreme_o = extreme_i;
      end
      default: begin
        class_o   = ClassNone;
        call_o    = 1'b0;
        extreme_o = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/threshold_run_segmenter_core.sv @@
// ----------------------------------------------------------------------------
// threshold_run_segmenter_core
// Splits a stream of smoothed log2-ratio samples into runs of one class
// (neutral, loss, gain) and emits one segment request per closed run.
//
//   Channel   Dir  Request contents
//   s_axis    in   tdata: sample_value[15:0]; tuser: sample_is_nan; tlast: last_sample
//   m_axis    out  tdata: seg_start, seg_end, extreme_value; tuser: mixture_class,
//                  call_flag; tlast: final_segment
//   cfg       in   write enable, register index 0..7, 16-bit data (no read-back)
//
// One sample per cycle sustained while the result register is not stalled.
// An accepted sample sits in the input register; classification, run update
// and grading are combinational from it, and a closing sample's segment is
// registered into the result register when the input register advances.
// A stalled result holds the input register, and s_axis_tready drops while
// that register is full. Reset clears run state and the sample index and
// loads the default bounds; no clearing pass is needed.
// ----------------------------------------------------------------------------
module threshold_run_segmenter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input samples
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample_value
  input  logic [0:0]  s_axis_tuser,   // [0] sample_is_nan
  input  logic        s_axis_tlast,   // last_sample
  // segments
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [19:0] seg_start, [39:20] seg_end,
                                      // [55:40] extreme_value
  output logic [4:0]  m_axis_tuser,   // [3:0] mixture_class, [4] call_flag
  output logic        m_axis_tlast,   // final_segment
  // configuration
  input  logic                            cfg_we_i,
  input  logic [trs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [trs_pkg::CfgDataW-1:0]    cfg_data_i
);
  import trs_pkg::*;

  // ---- configuration registers ----
  bounds_t bounds_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q.gain[0] <= GainRst0;
      bounds_q.gain[1] <= GainRst1;
      bounds_q.gain[2] <= GainRst2;
      bounds_q.gain[3] <= GainRst3;
      bounds_q.loss[0] <= LossRst0;
      bounds_q.loss[1] <= LossRst1;
      bounds_q.loss[2] <= LossRst2;
      bounds_q.loss[3] <= LossRst3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegGain0: bounds_q.gain[0] <= cfg_data_i[GainW-1:0];
        RegGain1: bounds_q.gain[1] <= cfg_data_i[GainW-1:0];
        RegGain2: bounds_q.gain[2] <= cfg_data_i[GainW-1:0];
        RegGain3: bounds_q.gain[3] <= cfg_data_i[GainW-1:0];
        RegLoss0: bounds_q.loss[0] <= cfg_data_i[LossW-1:0];
        RegLoss1: bounds_q.loss[1] <= cfg_data_i[LossW-1:0];
        RegLoss2: bounds_q.loss[2] <= cfg_data_i[LossW-1:0];
        RegLoss3: bounds_q.loss[3] <= cfg_data_i[LossW-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // ---- input register ----
  logic                    in_valid_q;
  logic signed [SampW-1:0] in_sample_q;
  logic                    in_nan_q;
  logic                    in_last_q;
  logic                    advance;
  logic                    out_valid_q;

  // stage moves on when it holds a sample and the result slot is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample_q <= $signed(s_axis_tdata);
      in_nan_q    <= s_axis_tuser[0];
      in_last_q   <= s_axis_tlast;
    end
  end

  // ---- classify, track, grade ----
  run_kind_e               kind;
  seg_t                    seg;
  logic [ClassW-1:0]       seg_class;
  logic                    seg_call;
  logic signed [SampW-1:0] seg_extreme;

  trs_classify u_classify (
    .sample_i (in_sample_q),
    .is_nan_i (in_nan_q),
    .gain0_i  (bounds_q.gain[0]),
    .loss0_i  ($signed(bounds_q.loss[0])),
    .kind_o   (kind)
  );

  trs_run_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sample_i (in_sample_q),
    .is_nan_i (in_nan_q),
    .last_i   (in_last_q),
    .kind_i   (kind),
    .seg_o    (seg)
  );

  trs_mixture u_mixture (
    .kind_i    (seg.kind),
    .extreme_i (seg.extreme),
    .bounds_i  (bounds_q),
    .class_o   (seg_class),
    .call_o    (seg_call),
    .extreme_o (seg_extreme)
  );

  // ---- result register ----
  logic [55:0] out_data_q;
  logic [4:0]  out_user_q;
  logic        out_last_q;
  logic        out_valid_d;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = seg.valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg.valid) begin
      out_data_q <= {seg_extreme, seg.seg_end, seg.seg_start};
      out_user_q <= {seg_call, seg_class};
      out_last_q <= seg.is_final;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/core/trs_checker.sv @@
// ----------------------------------------------------------------------------
// trs_checker
// Port-level checks on the segment stream, bound to the top level.
// ----------------------------------------------------------------------------
module trs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [4:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import trs_pkg::*;

  // a stalled segment request stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("segment request withdrawn while stalled");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[3:0] <= ClassGainFull))
    else $error("mixture class out of range");

  // fractional call exactly for the six partial classes
  a_call_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[4] ==
      ((m_axis_tuser[3:0] != ClassLossFull) && (m_axis_tuser[3:0] != ClassNone) &&
       (m_axis_tuser[3:0] != ClassGainFull))))
    else $error("call flag disagrees with mixture class");

  // a stalled segment request keeps its contents
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
      |=> $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("segment request changed while stalled");

endmodule

bind threshold_run_segmenter_core trs_checker u_trs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
